// ===== rtl/core/ucf_pkg.sv =====
package ucf_pkg;

  localparam int NODE_W = 7;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [1:0] color_t;

  localparam color_t COL_WHITE = 2'd0;
  localparam color_t COL_GRAY  = 2'd1;
  localparam color_t COL_BLACK = 2'd2;

  localparam node_t NODE_COUNT_RESET = 7'd64;

endpackage

// ===== rtl/core/ucf_edge_if.sv =====
interface ucf_edge_if;
  import ucf_pkg::*;
  logic  valid;
  logic  ready;
  node_t end_a;
  node_t end_b;
  logic  last_edge;

  modport source (output valid, end_a, end_b, last_edge, input ready);
  modport sink (input valid, end_a, end_b, last_edge, output ready);
endinterface

// ===== rtl/core/ucf_result_if.sv =====
interface ucf_result_if;
  import ucf_pkg::*;
  logic  valid;
  logic  ready;
  node_t cycle_node;
  logic  found;
  logic  last_result;

  modport source (output valid, cycle_node, found, last_result, input ready);
  modport sink (input valid, cycle_node, found, last_result, output ready);
endinterface

// ===== rtl/core/undirected_cycle_finder.sv =====
// undirected_cycle_finder
// edges: sink channel, one undirected edge per transaction (end_a, end_b,
//   last_edge). an edge is dropped if it is a self loop or out of range;
//   otherwise its pair bitmap and degrees are read and, unless the pair was
//   already seen, one neighbor list write per endpoint follows, all on
//   synchronous memories.
// results: source channel, one transaction per cycle node (found=1, last_result
//   on the final one) or a single transaction with found=0 when the graph has
//   no cycle.
// the edge marked last starts a depth-first walk; edges are not taken until
//   the walk ends. a neighbor scan passes W_TOP, W_NB and, for a usable
//   neighbor, W_COL; a push adds W_DEG, a pop W_POP1 and W_POP2, and each root
//   W_ROOT and W_ROOTC (with W_DEG when it starts a tree). the cycle is then
//   read back from the stack memory through W_ERD and W_EOUT for each node.
// a result waits in an output register; while the receiver stalls the next
//   edges are still taken, but emission of a new result holds.
// node_count is written through cfg_we/cfg_data only while idle; the user
//   must ensure it (not enforced); reset gives 64. rst (synchronous) returns
//   to edge loading with empty bitmap, degrees and colors; these are cleared
//   by per-entry valid bits, with no clearing pass, here and after each graph.
module undirected_cycle_finder #(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  ucf_pkg::node_t   cfg_data,
  ucf_edge_if.sink         edges,
  ucf_result_if.source     results
);
  import ucf_pkg::*;

  localparam int DW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = 2 * DW;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_NODES);
  localparam node_t MAX_N = NODE_W'(MAX_NODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_E1    = 4'd1;
  localparam logic [3:0] S_E2    = 4'd2;
  localparam logic [3:0] W_ROOT  = 4'd3;
  localparam logic [3:0] W_ROOTC = 4'd4;
  localparam logic [3:0] W_DEG   = 4'd5;
  localparam logic [3:0] W_TOP   = 4'd6;
  localparam logic [3:0] W_NB    = 4'd7;
  localparam logic [3:0] W_COL   = 4'd8;
  localparam logic [3:0] W_POP1  = 4'd9;
  localparam logic [3:0] W_POP2  = 4'd10;
  localparam logic [3:0] W_POS   = 4'd11;
  localparam logic [3:0] W_ERD   = 4'd12;
  localparam logic [3:0] W_EOUT  = 4'd13;
  localparam logic [3:0] W_NONE  = 4'd14;
  localparam logic [3:0] W_CLR   = 4'd15;

  logic [3:0] state;
  node_t node_count, n_eff;
  node_t lo, hi, root, u, par, v;
  logic last;
  logic [CW-1:0] sp, k, nxt, deg_u;

  // memories
  logic [MAX_NODES-1:0] pair_mem [MAX_NODES];
  logic [CW-1:0]        deg_mem  [MAX_NODES];
  color_t               col_mem  [MAX_NODES];
  node_t                nbr_mem  [2**AW];
  node_t                sn_mem   [MAX_NODES];
  logic [CW-1:0]        snx_mem  [MAX_NODES];
  logic [CW-1:0]        pos_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] pair_vld, deg_vld, col_vld;

  logic [MAX_NODES-1:0] pair_q;
  logic [CW-1:0] deg_q, snx_q, pos_q;
  color_t col_q;
  node_t nbr_q, sn_q;
  logic pvld_q, dvld_q, cvld_q;

  logic [MAX_NODES-1:0] prow;
  logic [CW-1:0] deg_rd;
  color_t col_rd;

  // port controls
  logic [DW-1:0] pair_ra, deg_ra, col_ra, sn_ra, pos_ra;
  logic [DW-1:0] pair_wa, deg_wa, col_wa, sn_wa, snx_wa, pos_wa;
  logic [AW-1:0] nbr_ra, nbr_wa;
  logic pair_we, deg_we, col_we, nbr_we, sn_we, snx_we, pos_we;
  logic [MAX_NODES-1:0] pair_wd;
  logic [CW-1:0] deg_wd, snx_wd, pos_wd;
  color_t col_wd;
  node_t nbr_wd, sn_wd;

  logic in_acc, out_free, in_ok;
  node_t in_lo, in_hi, in_lo1, lo1, hi1, root1, u1, v1, nbr1, sn1;
  logic [CW-1:0] sp_m1, sp_m2;

  assign in_acc   = edges.valid && edges.ready;
  assign out_free = !results.valid || results.ready;
  assign edges.ready = (state == S_IDLE);

  always_comb begin
    if (node_count == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = node_count;
    end
  end

  assign in_ok = (edges.end_a != '0) && (edges.end_b != '0) && (edges.end_a <= n_eff) &&
                 (edges.end_b <= n_eff) && (edges.end_a != edges.end_b);
  assign in_lo  = (edges.end_a < edges.end_b) ? edges.end_a : edges.end_b;
  assign in_hi  = (edges.end_a < edges.end_b) ? edges.end_b : edges.end_a;
  assign in_lo1 = in_lo - NODE_W'(1);
  assign lo1    = lo - NODE_W'(1);
  assign hi1    = hi - NODE_W'(1);
  assign root1  = root - NODE_W'(1);
  assign u1     = u - NODE_W'(1);
  assign v1     = v - NODE_W'(1);
  assign nbr1   = nbr_q - NODE_W'(1);
  assign sn1    = sn_q - NODE_W'(1);
  assign sp_m1  = sp - CW'(1);
  assign sp_m2  = sp - CW'(2);

  assign prow   = pvld_q ? pair_q : '0;
  assign deg_rd = dvld_q ? deg_q : '0;
  assign col_rd = cvld_q ? col_q : COL_WHITE;

  always_comb begin
    pair_ra = in_lo1[DW-1:0];
    deg_ra  = in_lo1[DW-1:0];
    col_ra  = root1[DW-1:0];
    sn_ra   = sp_m2[DW-1:0];
    pos_ra  = nbr1[DW-1:0];
    nbr_ra  = {u1[DW-1:0], nxt[DW-1:0]};
    pair_we = 1'b0;
    pair_wa = lo1[DW-1:0];
    pair_wd = prow | (MAX_NODES'(1) << hi1[DW-1:0]);
    deg_we  = 1'b0;
    deg_wa  = lo1[DW-1:0];
    deg_wd  = deg_rd + CW'(1);
    nbr_we  = 1'b0;
    nbr_wa  = {lo1[DW-1:0], deg_rd[DW-1:0]};
    nbr_wd  = hi;
    col_we  = 1'b0;
    col_wa  = root1[DW-1:0];
    col_wd  = COL_GRAY;
    sn_we   = 1'b0;
    sn_wa   = '0;
    sn_wd   = root;
    snx_we  = 1'b0;
    snx_wa  = sp_m1[DW-1:0];
    snx_wd  = nxt;
    pos_we  = 1'b0;
    pos_wa  = root1[DW-1:0];
    pos_wd  = '0;
    unique case (state)
      S_E1: begin
        deg_ra = hi1[DW-1:0];
        if (!prow[hi1[DW-1:0]]) begin
          pair_we = 1'b1;
          deg_we  = 1'b1;
          nbr_we  = 1'b1;
        end
      end
      S_E2: begin
        deg_we = 1'b1;
        deg_wa = hi1[DW-1:0];
        nbr_we = 1'b1;
        nbr_wa = {hi1[DW-1:0], deg_rd[DW-1:0]};
        nbr_wd = lo;
      end
      W_ROOTC: begin
        deg_ra = root1[DW-1:0];
        if (col_rd == COL_WHITE) begin
          col_we = 1'b1;
          sn_we  = 1'b1;
          pos_we = 1'b1;
        end
      end
      W_TOP: begin
        if (nxt >= deg_u) begin
          col_we = 1'b1;
          col_wa = u1[DW-1:0];
          col_wd = COL_BLACK;
        end
      end
      W_NB: col_ra = nbr1[DW-1:0];
      W_COL: begin
        deg_ra = v1[DW-1:0];
        pos_ra = v1[DW-1:0];
        if (col_rd == COL_WHITE && sp < MAX_C) begin
          col_we = 1'b1;
          col_wa = v1[DW-1:0];
          sn_we  = 1'b1;
          sn_wa  = sp[DW-1:0];
          sn_wd  = v;
          snx_we = 1'b1;
          pos_we = 1'b1;
          pos_wa = v1[DW-1:0];
          pos_wd = sp;
        end
      end
      W_POP1: deg_ra = sn1[DW-1:0];
      W_ERD: sn_ra = k[DW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_wa] <= pair_wd;
    pair_q <= pair_mem[pair_ra];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_q <= deg_mem[deg_ra];
    if (col_we) col_mem[col_wa] <= col_wd;
    col_q <= col_mem[col_ra];
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_q <= nbr_mem[nbr_ra];
    if (sn_we) sn_mem[sn_wa] <= sn_wd;
    sn_q <= sn_mem[sn_ra];
    if (snx_we) snx_mem[snx_wa] <= snx_wd;
    snx_q <= snx_mem[sn_ra];
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (rst || state == W_CLR) begin
      pair_vld <= '0;
      deg_vld  <= '0;
      col_vld  <= '0;
    end else begin
      if (pair_we) pair_vld[pair_wa] <= 1'b1;
      if (deg_we) deg_vld[deg_wa] <= 1'b1;
      if (col_we) col_vld[col_wa] <= 1'b1;
    end
    pvld_q <= pair_vld[pair_ra];
    dvld_q <= deg_vld[deg_ra];
    cvld_q <= col_vld[col_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sp            <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != W_NONE) results.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            lo   <= in_lo;
            hi   <= in_hi;
            last <= edges.last_edge;
            root <= NODE_W'(1);
            if (in_ok) begin
              state <= S_E1;
            end else if (edges.last_edge) begin
              state <= W_ROOT;
            end
          end
        end
        S_E1: begin
          if (!prow[hi1[DW-1:0]]) begin
            state <= S_E2;
          end else begin
            state <= last ? W_ROOT : S_IDLE;
          end
        end
        S_E2: state <= last ? W_ROOT : S_IDLE;
        W_ROOT: state <= (root > n_eff) ? W_NONE : W_ROOTC;
        W_ROOTC: begin
          if (col_rd == COL_WHITE) begin
            u     <= root;
            par   <= '0;
            nxt   <= '0;
            sp    <= CW'(1);
            state <= W_DEG;
          end else begin
            root  <= root + NODE_W'(1);
            state <= W_ROOT;
          end
        end
        W_DEG: begin
          deg_u <= deg_rd;
          state <= W_TOP;
        end
        W_TOP: begin
          if (nxt >= deg_u) begin
            sp <= sp_m1;
            if (sp == CW'(1)) begin
              root  <= root + NODE_W'(1);
              state <= W_ROOT;
            end else begin
              state <= W_POP1;
            end
          end else begin
            nxt   <= nxt + CW'(1);
            state <= W_NB;
          end
        end
        W_NB: begin
          v <= nbr_q;
          if (nbr_q == '0 || nbr_q > n_eff || nbr_q == par) begin
            state <= W_TOP;
          end else begin
            state <= W_COL;
          end
        end
        W_COL: begin
          case (col_rd)
            COL_WHITE: begin
              if (sp < MAX_C) begin
                par   <= u;
                u     <= v;
                nxt   <= '0;
                sp    <= sp + CW'(1);
                state <= W_DEG;
              end else begin
                state <= W_TOP;
              end
            end
            COL_GRAY: state <= W_POS;
            default: state <= W_TOP;
          endcase
        end
        W_POP1: begin
          u     <= sn_q;
          nxt   <= snx_q;
          state <= W_POP2;
        end
        W_POP2: begin
          deg_u <= deg_rd;
          par   <= (sp >= CW'(2)) ? sn_q : '0;
          state <= W_TOP;
        end
        W_POS: begin
          k     <= pos_q;
          state <= W_ERD;
        end
        W_ERD: begin
          if (out_free) state <= W_EOUT;
        end
        W_EOUT: begin
          results.valid       <= 1'b1;
          results.cycle_node  <= sn_q;
          results.found       <= 1'b1;
          results.last_result <= (k == sp_m1);
          if (k == sp_m1) begin
            state <= W_CLR;
          end else begin
            k     <= k + CW'(1);
            state <= W_ERD;
          end
        end
        W_NONE: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.cycle_node  <= '0;
            results.found       <= 1'b0;
            results.last_result <= 1'b1;
            state               <= W_CLR;
          end
        end
        W_CLR: begin
          sp    <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= MAX_C)
    else $error("stack pointer beyond depth");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst) edges.ready |-> sp == '0)
    else $error("edges taken while stack not empty");
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.found |-> results.last_result && results.cycle_node == '0)
    else $error("malformed no-cycle result");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    state == W_CLR |=> pair_vld == '0 && deg_vld == '0 && col_vld == '0)
    else $error("stores not cleared after graph");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    state == W_EOUT |-> !results.valid)
    else $error("result overwritten");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ucf_pkg::*;

  localparam int MAXN = 64;
  localparam int WATCHDOG = 400000;

  typedef struct packed {
    node_t a;
    node_t b;
    logic  last;
  } edge_item_t;

  typedef struct packed {
    node_t node;
    logic  found;
    logic  last;
  } cycle_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  node_t cfg_data = '0;

  ucf_edge_if edges_if();
  ucf_result_if results_if();

  undirected_cycle_finder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .edges(edges_if.sink), .results(results_if.source)
  );

  always #2 clk = ~clk;

  // predictor state
  int unsigned m_count;
  logic [63:0] m_pair [1:MAXN];
  int m_nbr [1:MAXN][0:MAXN-1];
  int m_deg [1:MAXN];
  color_t m_col [1:MAXN];
  int m_snode [0:MAXN-1];
  int m_snext [0:MAXN-1];
  int m_spos [1:MAXN];

  edge_item_t pending_edges[$];
  cycle_res_t expected_cycle[$];
  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic int eff_n();
    if (m_count < 1) return 1;
    if (m_count > MAXN) return MAXN;
    return m_count;
  endfunction

  function automatic void clear_graph();
    for (int i = 1; i <= MAXN; i++) begin
      m_pair[i] = '0;
      m_deg[i] = 0;
      m_col[i] = COL_WHITE;
      m_spos[i] = 0;
    end
  endfunction

  function automatic void add_edge(int a, int b);
    int n, lo, hi;
    n = eff_n();
    if (a == 0 || b == 0 || a > n || b > n || a == b) return;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    if (m_pair[lo][hi-1]) return;
    m_pair[lo][hi-1] = 1'b1;
    if (m_deg[lo] < MAXN) begin m_nbr[lo][m_deg[lo]] = hi; m_deg[lo]++; end
    if (m_deg[hi] < MAXN) begin m_nbr[hi][m_deg[hi]] = lo; m_deg[hi]++; end
  endfunction

  function automatic bit find_cycle();
    int n, sp, t, u, par, v;
    cycle_res_t r;
    n = eff_n();
    for (int root = 1; root <= n; root++) begin
      if (m_col[root] != COL_WHITE) continue;
      m_col[root] = COL_GRAY;
      m_snode[0] = root;
      m_snext[0] = 0;
      m_spos[root] = 0;
      sp = 1;
      while (sp > 0) begin
        t = sp - 1;
        u = m_snode[t];
        par = t > 0 ? m_snode[t-1] : 0;
        if (m_snext[t] >= m_deg[u]) begin
          m_col[u] = COL_BLACK;
          sp--;
          continue;
        end
        v = m_nbr[u][m_snext[t]];
        m_snext[t]++;
        if (v == 0 || v > n || v == par) continue;
        if (m_col[v] == COL_WHITE) begin
          if (sp >= MAXN) continue;
          m_col[v] = COL_GRAY;
          m_snode[sp] = v;
          m_snext[sp] = 0;
          m_spos[v] = sp;
          sp++;
        end else if (m_col[v] == COL_GRAY) begin
          for (int k = m_spos[v]; k <= t; k++) begin
            r.node = node_t'(m_snode[k]);
            r.found = 1'b1;
            r.last = (k == t);
            expected_cycle = {expected_cycle, r};
          end
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic void predict_edge(edge_item_t e);
    cycle_res_t r;
    add_edge(int'(e.a), int'(e.b));
    if (!e.last) return;
    if (!find_cycle()) begin
      r.node = '0; r.found = 1'b0; r.last = 1'b1;
      expected_cycle = {expected_cycle, r};
    end
    clear_graph();
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      edges_if.valid <= 1'b0;
    end else if (edges_if.valid && !edges_if.ready) begin
    end else begin
      if (edges_if.valid) begin
        predict_edge({edges_if.end_a, edges_if.end_b, edges_if.last_edge});
        void'(pending_edges.pop_front());
      end
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        edges_if.valid <= 1'b0;
      end else if (pending_edges.size() > 0) begin
        edge_item_t e;
        e = pending_edges[0];
        edges_if.valid <= 1'b1;
        edges_if.end_a <= e.a;
        edges_if.end_b <= e.b;
        edges_if.last_edge <= e.last;
        drv_gap <= gap_len();
      end else begin
        edges_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  int mon_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        cycle_res_t want;
        if (expected_cycle.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected result node=%0d found=%0b last=%0b",
                      results_if.cycle_node, results_if.found, results_if.last_result);
        end else begin
          want = expected_cycle.pop_front();
          if (want.node !== results_if.cycle_node || want.found !== results_if.found ||
              want.last !== results_if.last_result) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch exp node=%0d found=%0b last=%0b got node=%0d found=%0b last=%0b",
                       want.node, want.found, want.last, results_if.cycle_node,
                       results_if.found, results_if.last_result);
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) mon_gap <= gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((edges_if.valid && edges_if.ready) || (results_if.valid && results_if.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("undirected_cycle_finder regression: fail");
      $finish;
    end
  end

  task automatic push_edge(int a, int b, bit last);
    edge_item_t e;
    e.a = node_t'(a); e.b = node_t'(b); e.last = last;
    pending_edges = {pending_edges, e};
  endtask

  task automatic drain();
    while (pending_edges.size() > 0 || edges_if.valid || expected_cycle.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_count(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= node_t'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    m_count = v;
  endtask

  // graph of random edges, some of them self loops or out of range
  task automatic random_graph(int n);
    int ne, a, b, k;
    ne = $urandom_range(1, 10);
    for (int i = 0; i < ne; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        a = $urandom_range(0, 127); b = $urandom_range(0, 127);
      end else if (k < 14) begin
        a = $urandom_range(1, n); b = a;
      end else begin
        a = $urandom_range(1, n); b = $urandom_range(1, n);
      end
      push_edge(a, b, i == ne - 1);
    end
  endtask

  task automatic random_cycle(int n);
    int len, cur, first, nxt;
    len = $urandom_range(3, n < 8 ? n : 8);
    first = $urandom_range(1, n);
    cur = first;
    for (int i = 1; i < len; i++) begin
      nxt = $urandom_range(1, n);
      push_edge(cur, nxt, 0);
      cur = nxt;
    end
    push_edge(cur, first, 1);
  endtask

  initial begin
    int n;
    m_count = NODE_COUNT_RESET;
    clear_graph();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed
    push_edge(5, 5, 1);
    push_edge(1, 2, 0); push_edge(2, 3, 0); push_edge(1, 2, 0); push_edge(3, 1, 1);
    push_edge(64, 63, 0); push_edge(63, 62, 0); push_edge(62, 64, 1);
    push_edge(0, 3, 0); push_edge(127, 1, 0); push_edge(1, 2, 0); push_edge(2, 1, 1);
    push_edge(1, 2, 0); push_edge(2, 3, 0); push_edge(3, 4, 1);
    drain();
    set_count(3);
    push_edge(1, 2, 0); push_edge(2, 3, 0); push_edge(4, 1, 0); push_edge(3, 1, 1);
    drain();
    set_count(0);
    push_edge(1, 1, 0); push_edge(1, 2, 1);
    drain();
    set_count(127);
    push_edge(64, 1, 0); push_edge(1, 32, 0); push_edge(32, 64, 1);
    drain();
    set_count(10);
    push_edge(1, 2, 0); push_edge(2, 9, 0); push_edge(9, 1, 0);
    drain();
    set_count(3);
    push_edge(1, 3, 1);
    drain();

    // random
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: n = 64;
        1: n = 1;
        2: n = $urandom_range(3, 12);
        3: n = $urandom_range(13, 63);
        default: n = $urandom_range(3, 16);
      endcase
      set_count(n);
      for (int g = 0; g < 7; g++) begin
        if ($urandom_range(0, 2) == 0) random_graph(n < 2 ? 2 : n);
        else random_cycle(n < 3 ? 3 : n);
      end
      drain();
    end
    if (errors == 0 && expected_cycle.size() == 0)
      $display("undirected_cycle_finder regression: pass");
    else
      $display("undirected_cycle_finder regression: fail");
    $finish;
  end
endmodule
